FILE: rtl/core/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types and constants for the Josephus survivor block.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam int MAX_PEOPLE_DEF = 64;
  localparam int IN_W           = 7;
  localparam int OUT_W          = 7;
  localparam int STEP_W         = 10;
  localparam logic [STEP_W-1:0] STEP_RESET = 10'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SEEK,
    ST_WALK,
    ST_UNLINK,
    ST_FINISH
  } seq_state_t;

  // Write strobes for the two link memories.
  typedef struct packed {
    logic next_we;
    logic prev_we;
  } link_we_t;

  // Result handshake between the sequencer and the output register.
  typedef struct packed {
    logic valid;
    logic ready;
  } res_hs_t;

endpackage

FILE: rtl/core/jsv_ram.sv
// ----------------------------------------------------------------------------
// jsv_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module jsv_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/jsv_seq.sv
// ----------------------------------------------------------------------------
// jsv_seq
// Sequencer that builds the ring in the link memories and removes members
// one at a time until a single survivor is left.
// ----------------------------------------------------------------------------
module jsv_seq #(
  parameter int MAX_PEOPLE = jsv_pkg::MAX_PEOPLE_DEF,
  localparam int IDX_W = $clog2(MAX_PEOPLE),
  localparam int CNT_W = $clog2(MAX_PEOPLE + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jsv_pkg::IN_W-1:0]  people_count,
  input  logic [jsv_pkg::STEP_W-1:0] count_step,
  output jsv_pkg::res_hs_t          res_hs_o,
  input  logic                      res_ready,
  output logic [jsv_pkg::OUT_W-1:0] res_survivor,
  output jsv_pkg::link_we_t         link_we,
  output logic [IDX_W-1:0]          next_addr,
  output logic [IDX_W-1:0]          next_wdata,
  input  logic [IDX_W-1:0]          next_rdata,
  output logic [IDX_W-1:0]          prev_addr,
  output logic [IDX_W-1:0]          prev_wdata,
  input  logic [IDX_W-1:0]          prev_rdata
);

  localparam int WIDE_W = (CNT_W > jsv_pkg::IN_W) ? CNT_W : jsv_pkg::IN_W;

  jsv_pkg::seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          alive_r, alive_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [IDX_W-1:0]          cur_r, cur_nxt;
  logic [IDX_W-1:0]          start_r, start_nxt;
  logic [jsv_pkg::STEP_W-1:0] k_r, k_nxt;

  logic [WIDE_W-1:0]          n_ext;
  logic [CNT_W-1:0]           n_sat;
  logic [jsv_pkg::STEP_W-1:0] walk;
  logic [IDX_W-1:0]           last_idx;
  logic [IDX_W:0]             surv_wide;
  logic                       in_fire;

  // Clamp the requested count into 1..MAX_PEOPLE.
  always_comb begin
    n_ext = WIDE_W'(people_count);
    if (n_ext == '0) begin
      n_sat = CNT_W'(1);
    end else if (n_ext > WIDE_W'(MAX_PEOPLE)) begin
      n_sat = CNT_W'(MAX_PEOPLE);
    end else begin
      n_sat = CNT_W'(n_ext);
    end
  end

  assign walk      = (count_step == '0) ? '0 : count_step - 1'b1;
  assign last_idx  = IDX_W'(count_r - 1'b1);
  assign surv_wide = {1'b0, start_r} + 1'b1;
  assign in_ready  = (state_r == jsv_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign res_hs_o.valid = (state_r == jsv_pkg::ST_FINISH);
  assign res_hs_o.ready = res_ready;
  assign res_survivor   = jsv_pkg::OUT_W'(surv_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsv_pkg::ST_IDLE;
      alive_r <= '0;
      start_r <= '0;
    end else begin
      state_r <= state_nxt;
      alive_r <= alive_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    cur_r   <= cur_nxt;
    k_r     <= k_nxt;
  end

  // The FSM never reads in the same cycle that it writes, and every read
  // follows the last write in a later cycle, so no forwarding is needed.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    alive_nxt  = alive_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    start_nxt  = start_r;
    k_nxt      = k_r;
    link_we    = '0;
    next_addr  = cur_r;
    prev_addr  = cur_r;
    next_wdata = '0;
    prev_wdata = '0;

    unique case (state_r)
      jsv_pkg::ST_IDLE: begin
        if (in_fire) begin
          count_nxt = n_sat;
          idx_nxt   = '0;
          state_nxt = jsv_pkg::ST_BUILD;
        end
      end

      jsv_pkg::ST_BUILD: begin
        link_we.next_we = 1'b1;
        link_we.prev_we = 1'b1;
        next_addr       = idx_r;
        prev_addr       = idx_r;
        next_wdata      = (idx_r == last_idx) ? '0 : idx_r + 1'b1;
        prev_wdata      = (idx_r == '0) ? last_idx : idx_r - 1'b1;
        idx_nxt         = idx_r + 1'b1;
        if (idx_r == last_idx) begin
          alive_nxt = count_r;
          start_nxt = '0;
          cur_nxt   = '0;
          k_nxt     = '0;
          state_nxt = (count_r == CNT_W'(1)) ? jsv_pkg::ST_FINISH : jsv_pkg::ST_SEEK;
        end
      end

      jsv_pkg::ST_SEEK: begin
        next_addr = cur_r;
        prev_addr = cur_r;
        state_nxt = (k_r == walk) ? jsv_pkg::ST_UNLINK : jsv_pkg::ST_WALK;
      end

      jsv_pkg::ST_WALK: begin
        // Follow the link that just came out of memory and fetch the next one.
        cur_nxt   = next_rdata;
        k_nxt     = k_r + 1'b1;
        next_addr = next_rdata;
        prev_addr = next_rdata;
        if (k_nxt == walk) begin
          state_nxt = jsv_pkg::ST_UNLINK;
        end
      end

      jsv_pkg::ST_UNLINK: begin
        // Memory outputs hold the removed member's neighbors.
        link_we.next_we = 1'b1;
        link_we.prev_we = 1'b1;
        next_addr       = prev_rdata;
        next_wdata      = next_rdata;
        prev_addr       = next_rdata;
        prev_wdata      = prev_rdata;
        start_nxt       = next_rdata;
        cur_nxt         = next_rdata;
        alive_nxt       = alive_r - 1'b1;
        k_nxt           = '0;
        state_nxt = (alive_r == CNT_W'(2)) ? jsv_pkg::ST_FINISH : jsv_pkg::ST_SEEK;
      end

      jsv_pkg::ST_FINISH: begin
        if (res_ready) begin
          state_nxt = jsv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = jsv_pkg::ST_IDLE;
      end
    endcase
  end

  a_we_only_in_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (link_we.next_we || link_we.prev_we) |->
      (state_r == jsv_pkg::ST_BUILD || state_r == jsv_pkg::ST_UNLINK))
    else $error("link memory written outside build or unlink");

  a_ring_has_two_while_removing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jsv_pkg::ST_SEEK || state_r == jsv_pkg::ST_WALK ||
     state_r == jsv_pkg::ST_UNLINK) |-> (alive_r >= CNT_W'(2)))
    else $error("removal running with fewer than two members");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jsv_pkg::ST_WALK) |-> (k_r < walk))
    else $error("walk counter passed the step count");

  a_accept_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == jsv_pkg::ST_BUILD))
    else $error("accepted transaction did not start the ring build");

  a_finish_single_member: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_hs_o.valid) |-> (alive_r == CNT_W'(1)))
    else $error("result raised with more than one member left");

endmodule

FILE: rtl/core/josephus_survivor.sv
// ----------------------------------------------------------------------------
// josephus_survivor
// Josephus elimination on a doubly linked ring held in two link memories.
//
//   channel  | ports                               | direction
//   ---------+-------------------------------------+----------
//   input    | in_valid/in_ready, in_people_count  | in
//   result   | out_valid/out_ready, out_survivor   | out
//   config   | cfg_we, cfg_wdata (count_step)      | in
//
// One transaction first writes the ring into both link memories, then removes
// members one at a time; each hop waits on the registered read of the
// next-link memory.
// Reset is synchronous and active low; count_step resets to 1.
// A new transaction is accepted while the previous result waits in the
// output register; the sequencer holds its result until that register frees.
// ----------------------------------------------------------------------------
module josephus_survivor #(
  parameter int MAX_PEOPLE = jsv_pkg::MAX_PEOPLE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jsv_pkg::IN_W-1:0]    in_people_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jsv_pkg::OUT_W-1:0]   out_survivor,
  input  logic                        cfg_we,
  input  logic [jsv_pkg::STEP_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_PEOPLE);

  logic [jsv_pkg::STEP_W-1:0] count_step_r;
  logic                       out_valid_r;
  logic [jsv_pkg::OUT_W-1:0]  out_survivor_r;

  jsv_pkg::res_hs_t           res_hs;
  logic                       res_ready;
  logic [jsv_pkg::OUT_W-1:0]  res_survivor;
  jsv_pkg::link_we_t          link_we;
  logic [IDX_W-1:0]           next_addr, next_wdata, next_rdata;
  logic [IDX_W-1:0]           prev_addr, prev_wdata, prev_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_step_r <= jsv_pkg::STEP_RESET;
    end else if (cfg_we) begin
      count_step_r <= cfg_wdata;
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_hs.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_hs.valid && res_ready) begin
      out_survivor_r <= res_survivor;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_survivor = out_survivor_r;

  jsv_seq #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .people_count (in_people_count),
    .count_step   (count_step_r),
    .res_hs_o     (res_hs),
    .res_ready    (res_ready),
    .res_survivor (res_survivor),
    .link_we      (link_we),
    .next_addr    (next_addr),
    .next_wdata   (next_wdata),
    .next_rdata   (next_rdata),
    .prev_addr    (prev_addr),
    .prev_wdata   (prev_wdata),
    .prev_rdata   (prev_rdata)
  );

  jsv_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PEOPLE)
  ) u_next_ram (
    .clk   (clk),
    .we    (link_we.next_we),
    .addr  (next_addr),
    .wdata (next_wdata),
    .rdata (next_rdata)
  );

  jsv_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PEOPLE)
  ) u_prev_ram (
    .clk   (clk),
    .we    (link_we.prev_we),
    .addr  (prev_addr),
    .wdata (prev_wdata),
    .rdata (prev_rdata)
  );

endmodule

FILE: bench/tb_josephus_survivor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_josephus_survivor
// Self-checking bench for the Josephus survivor block. A scoreboard class
// replays every accepted people count on its own linked ring and queues the
// survivor it finds. Each returned survivor is checked against that queue.
// Directed counts cover the edges of the count and step ranges. Random
// phases follow with fresh step values, random idling on both channels and
// one long result hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module tb_josephus_survivor;

  localparam int CAP         = jsv_pkg::MAX_PEOPLE_DEF;
  localparam int IDX_W       = $clog2(CAP);
  localparam int IN_W        = jsv_pkg::IN_W;
  localparam int OUT_W       = jsv_pkg::OUT_W;
  localparam int STEP_W      = jsv_pkg::STEP_W;
  localparam int HALF_PERIOD = 4;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = 200;

  class survivor_board;
    logic [STEP_W-1:0] step_m;
    logic [IDX_W-1:0]  fwd[CAP];
    logic [IDX_W-1:0]  back[CAP];
    logic [OUT_W-1:0]  survivor_q[$];
    int                errors;

    function new();
      step_m = jsv_pkg::STEP_RESET;
      errors = 0;
    endfunction

    function void set_step(logic [STEP_W-1:0] value);
      step_m = value;
    endfunction

    // Eliminates members on a private ring and returns the last one left.
    function logic [OUT_W-1:0] predict_survivor(logic [IN_W-1:0] people);
      int unsigned members, alive, hops, cur, prior, later, head;
      members = people;
      if (members < 1) members = 1;
      if (members > CAP) members = CAP;
      for (int i = 0; i < members; i++) begin
        fwd[i]  = IDX_W'((i + 1 < members) ? i + 1 : 0);
        back[i] = IDX_W'((i > 0) ? i - 1 : members - 1);
      end
      // A step of zero behaves like a step of one.
      hops  = (step_m > 0) ? step_m - 1 : 0;
      alive = members;
      head  = 0;
      while (alive > 1) begin
        cur = head;
        for (int h = 0; h < hops; h++) cur = fwd[cur];
        prior = back[cur];
        later = fwd[cur];
        fwd[prior] = IDX_W'(later);
        back[later] = IDX_W'(prior);
        head = later;
        alive--;
      end
      return OUT_W'(head + 1);
    endfunction

    function void note_people(logic [IN_W-1:0] people);
      survivor_q.push_back(predict_survivor(people));
    endfunction

    function void check_survivor(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (survivor_q.size() == 0) begin
        $display("%0t: unexpected survivor transaction: expected none, actual %0d",
                 $time, got);
        errors++;
      end else begin
        want = survivor_q.pop_front();
        if (got !== want) begin
          $display("%0t: survivor mismatch: expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return survivor_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [IN_W-1:0]   in_people_count;
  logic              out_valid;
  logic              out_ready;
  logic [OUT_W-1:0]  out_survivor;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  logic              calm;
  logic              hold_request;
  int                hold_left;

  survivor_board board = new();

  josephus_survivor #(
    .MAX_PEOPLE(CAP)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_people_count(in_people_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_survivor   (out_survivor),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Called right after a falling edge; returns right after the falling edge
  // that follows acceptance, leaving valid high for a back-to-back item.
  task automatic send_people(input logic [IN_W-1:0] people);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_people_count = people;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_people(people);
    @(negedge clk);
  endtask

  // Waits for the block to go idle, then loads a new step value.
  task automatic write_step(input logic [STEP_W-1:0] value);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    board.set_step(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(input int step_lo, input int step_hi, input int items,
                              input int people_hi, input bit with_hold, input bit quiet);
    logic [IN_W-1:0] people;
    write_step(STEP_W'($urandom_range(step_hi, step_lo)));
    calm = quiet;
    if (with_hold) hold_request = 1'b1;
    repeat (items) begin
      if (people_hi > CAP) begin
        people = IN_W'($urandom_range(2**IN_W - 1));
      end else if ($urandom_range(7) == 0) begin
        // Out-of-range counts; large ones only where the step keeps them cheap.
        people = (people_hi == CAP) ? IN_W'($urandom_range(2**IN_W - 1, CAP + 1)) : '0;
      end else begin
        people = IN_W'($urandom_range(people_hi, 1));
      end
      send_people(people);
    end
    calm = 1'b0;
  endtask

  // Result side: random back-pressure plus one long counted hold-off.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = calm || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_survivor(out_survivor);
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_people_count = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    calm            = 1'b0;
    hold_request    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Step left at its reset value of one.
    send_people(IN_W'(0));
    send_people(IN_W'(1));
    send_people(IN_W'(2));
    send_people(IN_W'(3));
    send_people(IN_W'(42));
    send_people(IN_W'(CAP));
    send_people(IN_W'(CAP + 1));
    send_people(IN_W'(2**IN_W - 1));

    // A zero step removes the start member each time.
    write_step('0);
    send_people(IN_W'(1));
    send_people(IN_W'(7));
    send_people(IN_W'(CAP));
    send_people(IN_W'(100));

    // Largest step; only one full ring since the block walks every hop.
    write_step({STEP_W{1'b1}});
    send_people(IN_W'(1));
    send_people(IN_W'(2));
    send_people(IN_W'(3));
    send_people(IN_W'(8));
    send_people(IN_W'(CAP));

    write_step(STEP_W'(2));
    send_people(IN_W'(41));
    send_people(IN_W'(0));
    send_people(IN_W'(2**IN_W - 1));
    send_people(IN_W'(5));

    random_phase(1, 12, 25, CAP, 1'b0, 1'b0);
    random_phase(1, 3, 20, 8, 1'b1, 1'b0);
    random_phase(512, 1023, 12, 5, 1'b0, 1'b0);
    random_phase(1, 40, 25, CAP, 1'b0, 1'b1);
    random_phase(0, 1023, 10, 4, 1'b0, 1'b0);
    random_phase(1, 8, 25, 2**IN_W - 1, 1'b0, 1'b0);

    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Roughly ten times the slowest expected run.
  initial begin
    #32_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
